/* src/bsc_pkg.sv */
`default_nettype none

package bsc_pkg;

  // Sprite geometry is fixed; only the display size varies.
  localparam int SPRITE_WIDTH  = 32;
  localparam int SPRITE_HEIGHT = 16;

  localparam int POS_X_W = 7;  // holds 0..96
  localparam int POS_Y_W = 6;  // holds 0..48

  localparam logic [15:0] STEP_INTERVAL_RST = 16'd50;

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_READ = 1'b1
  } op_e;

  // Sprite position after a transaction plus the move flag.
  typedef struct packed {
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic               moved;
  } motion_t;

  // Two pages of 32 column bytes, bit n = row n of the page.
  localparam logic [7:0] SPRITE_ROM [0:63] = '{
    8'h00, 8'h00, 8'h00, 8'hE0, 8'hEC, 8'hEC, 8'h0C, 8'h0C,
    8'h8C, 8'hDC, 8'hFC, 8'hFC, 8'h3C, 8'h7C, 8'hF8, 8'hE0,
    8'hC0, 8'hE0, 8'h70, 8'h38, 8'h1C, 8'hEC, 8'hEC, 8'h6C,
    8'h0C, 8'h0C, 8'h8C, 8'hF8, 8'hF8, 8'h70, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h30, 8'h33, 8'h33, 8'h73, 8'h73, 8'h71,
    8'h79, 8'h79, 8'h78, 8'h78, 8'h58, 8'h58, 8'h59, 8'h5F,
    8'h5B, 8'h79, 8'h78, 8'h78, 8'h79, 8'h7B, 8'h73, 8'h73,
    8'h73, 8'h31, 8'h31, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00
  };

endpackage

`default_nettype wire

/* src/bsc_motion.sv */
`default_nettype none

module bsc_motion #(
  parameter int MaxX = 96,
  parameter int MaxY = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 tick_i,      // tick transaction in the input register
  input  wire logic                 advance_i,   // that transaction moves on this edge
  input  wire logic [15:0]          now_ms_i,
  input  wire logic [15:0]          interval_i,
  output bsc_pkg::motion_t          motion_o
);

  localparam int XW = bsc_pkg::POS_X_W;
  localparam int YW = bsc_pkg::POS_Y_W;

  logic [XW-1:0] pos_x_q, pos_x_d;
  logic [YW-1:0] pos_y_q, pos_y_d;
  logic          neg_x_q, neg_x_d;
  logic          neg_y_q, neg_y_d;
  logic [15:0]   last_q;
  logic [15:0]   elapsed;
  logic          go;

  assign elapsed = now_ms_i - last_q;  // wraps mod 2^16
  assign go      = tick_i && (elapsed > interval_i);

  always_comb begin
    pos_x_d = pos_x_q;
    neg_x_d = neg_x_q;
    pos_y_d = pos_y_q;
    neg_y_d = neg_y_q;
    if (go) begin
      // hitting an edge: hold at the edge, reverse
      if (neg_x_q) begin
        if (pos_x_q == '0) neg_x_d = 1'b0;
        else               pos_x_d = pos_x_q - XW'(1);
      end else begin
        if (pos_x_q == XW'(MaxX)) neg_x_d = 1'b1;
        else                      pos_x_d = pos_x_q + XW'(1);
      end
      if (neg_y_q) begin
        if (pos_y_q == '0) neg_y_d = 1'b0;
        else               pos_y_d = pos_y_q - YW'(1);
      end else begin
        if (pos_y_q == YW'(MaxY)) neg_y_d = 1'b1;
        else                      pos_y_d = pos_y_q + YW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      neg_x_q <= 1'b0;
      neg_y_q <= 1'b0;
      last_q  <= '0;
    end else if (advance_i) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      neg_x_q <= neg_x_d;
      neg_y_q <= neg_y_d;
      if (go) last_q <= now_ms_i;
    end
  end

  assign motion_o.pos_x = pos_x_d;
  assign motion_o.pos_y = pos_y_d;
  assign motion_o.moved = go;

endmodule

`default_nettype wire

/* src/bsc_raster.sv */
`default_nettype none

module bsc_raster #(
  parameter int DisplayWidth  = 128,
  parameter int DisplayHeight = 32
) (
  input  wire logic [1:0]                    page_i,
  input  wire logic [6:0]                    column_i,
  input  wire logic [bsc_pkg::POS_X_W-1:0]   pos_x_i,
  input  wire logic [bsc_pkg::POS_Y_W-1:0]   pos_y_i,
  output logic      [7:0]                    frame_byte_o
);

  logic [7:0]  sx;       // signed column offset into the sprite
  logic        col_hit;
  logic [15:0] col_bits; // one sprite column, both pages
  logic [7:0]  dy;       // signed row offset of bit 0
  logic [7:0]  sy  [8];
  logic [6:0]  row [8];

  assign sx = {1'b0, column_i} - {1'b0, pos_x_i};
  assign col_hit = ({1'b0, column_i} < 8'(DisplayWidth)) && !sx[7] && (sx[6:5] == 2'b00);

  assign col_bits = {bsc_pkg::SPRITE_ROM[{1'b1, sx[4:0]}],
                     bsc_pkg::SPRITE_ROM[{1'b0, sx[4:0]}]};

  assign dy = {3'b000, page_i, 3'b000} - {2'b00, pos_y_i};

  always_comb begin
    frame_byte_o = '0;
    for (int n = 0; n < 8; n++) begin
      sy[n]  = dy + 8'(n);
      row[n] = {2'b00, page_i, 3'(n)};
      if (col_hit && !sy[n][7] && (sy[n][6:4] == 3'b000) &&
          (row[n] < 7'(DisplayHeight))) begin
        frame_byte_o[n] = col_bits[sy[n][3:0]];
      end
    end
  end

endmodule

`default_nettype wire

/* src/bouncing_sprite_compositor_core.sv */
`default_nettype none
// Pipeline: each input transaction passes the input register, then the result register.
// Throughput: one transaction per cycle while out_stall_i does not hold a full result
//   register, with the position update and the two-byte sprite ROM lookup done combinationally.
// Reset (rst_ni low, asynchronous): pipeline empty, sprite at (0,0) moving right and
//   down, last move time 0, step_interval 50. No clearing pass is needed.

module bouncing_sprite_compositor_core #(
  parameter int DISPLAY_WIDTH  = 128,  // 32..128
  parameter int DISPLAY_HEIGHT = 32    // 16..64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [0:0]  operation_i,
  input  wire logic [15:0] now_ms_i,
  input  wire logic [1:0]  page_i,
  input  wire logic [6:0]  column_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       frame_byte_o,
  output logic [6:0]       sprite_x_o,
  output logic [4:0]       sprite_y_o,
  output logic             moved_o
);

  localparam int MAX_X = DISPLAY_WIDTH - bsc_pkg::SPRITE_WIDTH;
  localparam int MAX_Y = DISPLAY_HEIGHT - bsc_pkg::SPRITE_HEIGHT;

  // Configuration: always ready; only written while idle is a rule for the user, not enforced here.
  logic [15:0] interval_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= bsc_pkg::STEP_INTERVAL_RST;
    end else if (cfg_valid_i) begin
      interval_q <= cfg_data_i;
    end
  end

  // Input register stage.
  logic            s1_valid_q;
  bsc_pkg::op_e    op_q;
  logic [15:0]     now_q;
  logic [1:0]      page_q;
  logic [6:0]      column_q;

  // s1 hands off whenever the result register is free or being drained.
  logic adv2;
  logic accept;

  assign adv2       = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv2;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (adv2) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= bsc_pkg::op_e'(operation_i);
      now_q    <= now_ms_i;
      page_q   <= page_i;
      column_q <= column_i;
    end
  end

  // Sprite motion state; commits when the transaction moves to the result register.
  bsc_pkg::motion_t motion;

  bsc_motion #(
    .MaxX (MAX_X),
    .MaxY (MAX_Y)
  ) u_motion (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (s1_valid_q && (op_q == bsc_pkg::OP_TICK)),
    .advance_i  (adv2),
    .now_ms_i   (now_q),
    .interval_i (interval_q),
    .motion_o   (motion)
  );

  // Frame byte against the position as of this transaction (reads never move it).
  logic [7:0] pix;

  bsc_raster #(
    .DisplayWidth  (DISPLAY_WIDTH),
    .DisplayHeight (DISPLAY_HEIGHT)
  ) u_raster (
    .page_i       (page_q),
    .column_i     (column_q),
    .pos_x_i      (motion.pos_x),
    .pos_y_i      (motion.pos_y),
    .frame_byte_o (pix)
  );

  // Result register.
  logic out_valid_q;
  logic [7:0] pixel_q;
  logic [6:0] sx_q;
  logic [4:0] sy_q;
  logic       moved_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv2) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      pixel_q <= (op_q == bsc_pkg::OP_READ) ? pix : 8'h00;
      sx_q    <= motion.pos_x;
      sy_q    <= motion.pos_y[4:0];  // top row reported modulo 32
      moved_q <= motion.moved;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = pixel_q;
  assign sprite_x_o   = sx_q;
  assign sprite_y_o   = sy_q;
  assign moved_o      = moved_q;

`ifndef SYNTH
  // A tick transaction never carries frame data.
  a_moved_no_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && moved_o |-> frame_byte_o == 8'h00)
    else $error("moved result carries pixel data");

  // Sprite never leaves the horizontal range.
  a_x_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, sprite_x_o} <= 8'(MAX_X))
    else $error("sprite_x out of range");

  // Input is stalled only while the input register holds a blocked transaction.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled without cause");

  // A move by a tick that leaves the input register shows up as a moved result.
  a_moved_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv2 && motion.moved |=> out_valid_o && moved_o)
    else $error("move lost on the way to the result register");
`endif

endmodule

`default_nettype wire

/* dv/tb_bouncing_sprite_compositor_core.sv */
`timescale 1ns / 100ps

module tb_bouncing_sprite_compositor_core;

  // Display geometry under test (block defaults).
  localparam int DISP_W = 128;
  localparam int DISP_H = 32;
  localparam int MAX_X  = DISP_W - bsc_pkg::SPRITE_WIDTH;
  localparam int MAX_Y  = DISP_H - bsc_pkg::SPRITE_HEIGHT;

  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES   = 4;     // pipeline is two deep
  localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transaction
  localparam int REPORT_LIMIT   = 10;

  // One result transaction as seen on the output ports.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic [6:0] sprite_x;
    logic [4:0] sprite_y;
    logic       moved;
  } frame_result_t;

  // Tracks sprite motion and frame contents; holds the expected results in order.
  class frame_scoreboard;
    logic [15:0]   interval_ms;
    logic [15:0]   last_step_ms;
    int            cur_x;
    int            cur_y;
    bit            heading_left;
    bit            heading_up;
    frame_result_t pending_frames[$];
    int            mismatches;

    function new();
      interval_ms  = bsc_pkg::STEP_INTERVAL_RST;
      last_step_ms = '0;
      cur_x        = 0;
      cur_y        = 0;
      heading_left = 1'b0;
      heading_up   = 1'b0;
      mismatches   = 0;
    endfunction

    function void set_interval(logic [15:0] v);
      interval_ms = v;
    endfunction

    // One step along an axis; clamps at either edge and flags a turn-around.
    function int bounce(int pos, bit neg, int hi, output bit turned);
      int p;
      p = neg ? pos - 1 : pos + 1;
      turned = 1'b0;
      if (p < 0) begin
        p = 0;
        turned = 1'b1;
      end else if (p > hi) begin
        p = hi;
        turned = 1'b1;
      end
      return p;
    endfunction

    // Sprite drawn on an empty frame, clipped to the display.
    function logic [7:0] compose_byte(logic [1:0] page, logic [6:0] col);
      logic [7:0] acc;
      logic [7:0] rom_b;
      int sx;
      int row;
      int sy;
      acc = '0;
      sx = int'(col) - cur_x;
      if (int'(col) >= DISP_W || sx < 0 || sx >= bsc_pkg::SPRITE_WIDTH) return acc;
      for (int n = 0; n < 8; n++) begin
        row = int'(page) * 8 + n;
        sy  = row - cur_y;
        if (row < DISP_H && sy >= 0 && sy < bsc_pkg::SPRITE_HEIGHT) begin
          rom_b  = bsc_pkg::SPRITE_ROM[(sy / 8) * bsc_pkg::SPRITE_WIDTH + sx];
          acc[n] = rom_b[sy % 8];
        end
      end
      return acc;
    endfunction

    // Called once per accepted input transaction.
    function void note_item(bsc_pkg::op_e op, logic [15:0] now, logic [1:0] page,
                            logic [6:0] col);
      frame_result_t r;
      logic [15:0]   elapsed;
      bit            turned;
      r = '0;
      if (op == bsc_pkg::OP_TICK) begin
        elapsed = now - last_step_ms;  // wraps mod 2^16
        if (elapsed > interval_ms) begin
          last_step_ms = now;
          cur_x = bounce(cur_x, heading_left, MAX_X, turned);
          heading_left ^= turned;
          cur_y = bounce(cur_y, heading_up, MAX_Y, turned);
          heading_up ^= turned;
          r.moved = 1'b1;
        end
      end else begin
        r.frame_byte = compose_byte(page, col);
      end
      r.sprite_x = 7'(cur_x);
      r.sprite_y = 5'(cur_y);
      pending_frames.push_back(r);
    endfunction

    // Called once per accepted result transaction.
    function void check_frame(frame_result_t got);
      frame_result_t want;
      if (pending_frames.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result: pix=%02h x=%0d y=%0d moved=%0b",
                   got.frame_byte, got.sprite_x, got.sprite_y, got.moved);
        mismatches++;
        return;
      end
      want = pending_frames.pop_front();
      if (got.frame_byte !== want.frame_byte || got.sprite_x !== want.sprite_x ||
          got.sprite_y !== want.sprite_y || got.moved !== want.moved) begin
        if (mismatches < REPORT_LIMIT)
          $display("mismatch: expected pix=%02h x=%0d y=%0d moved=%0b,",
                   want.frame_byte, want.sprite_x, want.sprite_y, want.moved,
                   " got pix=%02h x=%0d y=%0d moved=%0b",
                   got.frame_byte, got.sprite_x, got.sprite_y, got.moved);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [0:0]  operation_i;
  logic [15:0] now_ms_i;
  logic [1:0]  page_i;
  logic [6:0]  column_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  frame_byte_o;
  logic [6:0]  sprite_x_o;
  logic [4:0]  sprite_y_o;
  logic        moved_o;

  frame_scoreboard sb;

  // Idle controls shared by the sender and the result sink.
  bit          tx_idle;
  bit          rx_idle;
  bit          hold_req;    // sink raises a long stall when set
  logic [15:0] clock_ms;    // running millisecond timer for well-formed ticks

  bouncing_sprite_compositor_core #(
    .DISPLAY_WIDTH (DISP_W),
    .DISPLAY_HEIGHT(DISP_H)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .now_ms_i    (now_ms_i),
    .page_i      (page_i),
    .column_i    (column_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .frame_byte_o(frame_byte_o),
    .sprite_x_o  (sprite_x_o),
    .sprite_y_o  (sprite_y_o),
    .moved_o     (moved_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one input transaction and hold it until accepted, then maybe idle.
  task automatic push_item(bsc_pkg::op_e op, logic [15:0] now, logic [1:0] page,
                           logic [6:0] col);
    int gap;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    now_ms_i    <= now;
    page_i      <= page;
    column_i    <= col;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(op, now, page, col);
    gap = (tx_idle && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits on the clock before testing, so valid is never dropped and raised in one step.
  task automatic wait_drained();
    do @(posedge clk_i); while (sb.pending_frames.size() != 0);
  endtask

  // Register writes only go in with the pipeline empty.
  task automatic write_interval(logic [15:0] v);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_interval(v);
  endtask

  // Mostly well-formed ticks from a running timer plus reads around the sprite;
  // the rest is timer jumps and reads anywhere on the frame.
  task automatic run_random(int count, int max_delta, bit tx_gaps, bit rx_gaps,
                            bit pause_mid, bit hold_mid);
    bsc_pkg::op_e op;
    logic [15:0]  now;
    logic [1:0]   page;
    logic [6:0]   col;
    int           r;
    int           i;
    tx_idle = tx_gaps;
    rx_idle = rx_gaps;
    for (i = 0; i < count; i++) begin
      // receiver goes quiet while we keep offering: fills the pipe
      if (hold_mid && i == count / 3) hold_req = 1'b1;
      // sender stops and lets every outstanding result come back
      if (pause_mid && i == (2 * count) / 3) begin
        in_valid_i <= 1'b0;
        wait_drained();
      end
      r    = $urandom_range(0, 99);
      page = 2'($urandom);
      col  = 7'($urandom);
      now  = 16'($urandom);
      if (r < 55) begin
        op = bsc_pkg::OP_TICK;
        if (r < 5) clock_ms = 16'($urandom);
        else clock_ms += 16'($urandom_range(0, max_delta));
        now = clock_ms;
      end else begin
        op = bsc_pkg::OP_READ;
        if (r < 85) col = 7'(sb.cur_x + $urandom_range(0, bsc_pkg::SPRITE_WIDTH - 1));
      end
      push_item(op, now, page, col);
    end
  endtask

  // Result sink: checks accepted results and drives the stall pattern.
  initial begin : result_sink
    int            stall_left;
    int            hold_left;
    frame_result_t got;
    stall_left  = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got = {frame_byte_o, sprite_x_o, sprite_y_o, moved_o};
        sb.check_frame(got);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (rx_idle && $urandom_range(0, 99) < 25) begin
        stall_left = idle_len() - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Ends the run if no transaction of any kind happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("[bouncing_sprite_compositor_core] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] rnd_iv;
    sb          = new();
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    operation_i = bsc_pkg::OP_TICK;
    now_ms_i    = '0;
    page_i      = '0;
    column_i    = '0;
    tx_idle     = 1'b0;
    rx_idle     = 1'b0;
    hold_req    = 1'b0;
    clock_ms    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset interval, sprite at the origin.
    push_item(bsc_pkg::OP_READ, 16'h0000, 2'd0, 7'd0);     // blank sprite corner
    push_item(bsc_pkg::OP_READ, 16'h0000, 2'd0, 7'd3);     // top page of sprite
    push_item(bsc_pkg::OP_READ, 16'h0000, 2'd1, 7'd3);     // bottom page of sprite
    push_item(bsc_pkg::OP_READ, 16'h0000, 2'd2, 7'd3);     // rows below the sprite
    push_item(bsc_pkg::OP_READ, 16'h0000, 2'd0, 7'd32);    // column just right of sprite
    push_item(bsc_pkg::OP_READ, 16'hFFFF, 2'd3, 7'd127);   // far corner, all ones
    push_item(bsc_pkg::OP_TICK, 16'd0,    2'd0, 7'd0);     // no time elapsed
    push_item(bsc_pkg::OP_TICK, 16'd50,   2'd0, 7'd0);     // equal to interval: no move
    push_item(bsc_pkg::OP_TICK, 16'd51,   2'd0, 7'd0);     // one past: move
    push_item(bsc_pkg::OP_READ, 16'h0000, 2'd0, 7'd0);     // left of shifted sprite
    push_item(bsc_pkg::OP_READ, 16'h0000, 2'd0, 7'd4);
    push_item(bsc_pkg::OP_READ, 16'h0000, 2'd2, 7'd10);    // last sprite row lands in page 2
    push_item(bsc_pkg::OP_READ, 16'h0000, 2'd0, 7'd33);    // just right of shifted sprite
    push_item(bsc_pkg::OP_TICK, 16'hFFFF, 2'd3, 7'd127);   // large elapsed, unused fields high
    push_item(bsc_pkg::OP_TICK, 16'd20,   2'd0, 7'd0);     // timer wrapped, small elapsed
    push_item(bsc_pkg::OP_TICK, 16'd102,  2'd0, 7'd0);     // elapsed across wrap > interval
    push_item(bsc_pkg::OP_TICK, 16'h8000, 2'd0, 7'd0);
    push_item(bsc_pkg::OP_READ, 16'h5555, 2'd1, 7'd40);
    push_item(bsc_pkg::OP_READ, 16'hAAAA, 2'd2, 7'd127);

    // Largest interval: the sprite can never move.
    write_interval(16'hFFFF);
    run_random(40, 65535, 1'b1, 1'b1, 1'b0, 1'b0);

    // Zero interval: any timer change moves; long hold-off and a drain pause.
    write_interval(16'h0000);
    clock_ms = 16'($urandom);
    run_random(300, 2, 1'b1, 1'b1, 1'b1, 1'b1);

    // Small random interval, back-to-back traffic with no idling.
    rnd_iv = 16'($urandom_range(1, 30));
    write_interval(rnd_iv);
    run_random(300, 2 * int'(rnd_iv) + 4, 1'b0, 1'b0, 1'b0, 1'b0);

    // Full-range interval with full-range timer steps.
    write_interval(16'($urandom));
    run_random(100, 65535, 1'b1, 1'b1, 1'b0, 1'b0);

    write_interval(16'd3);
    run_random(200, 8, 1'b1, 1'b0, 1'b0, 1'b1);

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_frames.size() == 0) begin
      $display("[bouncing_sprite_compositor_core] OK");
    end else begin
      $display("[bouncing_sprite_compositor_core] ERROR");
    end
    $finish;
  end

endmodule
